// ----- sv/gcn_pkg.sv -----
// shared constants for the geodesic cell neighbor block
`default_nettype none
package gcn_pkg;

   // fixed field widths
   localparam int CELL_W  = 16;
   localparam int FREQ_W  = 7;
   localparam int COUNT_W = 3;

   // default largest frequency the datapath is sized for
   localparam int DEFAULT_MAX_FREQUENCY = 64;

   // neighbor counts
   localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_PENT = 3'd5;
   localparam logic [COUNT_W-1:0] COUNT_HEX  = 3'd6;

   // direction pattern codes: {mid, bot, top, rem_zero}
   localparam logic [3:0] HALF_TOP         = 4'd2;
   localparam logic [3:0] HALF_TOP_CORNER  = 4'd3;
   localparam logic [3:0] HALF_BOT_CORNER  = 4'd5;
   localparam logic [3:0] HALF_N_EDGE      = 4'd10;
   localparam logic [3:0] HALF_N_CORNER    = 4'd11;
   localparam logic [3:0] HALF_2N_CORNER   = 4'd13;

endpackage
`default_nettype wire

// ----- sv/gcn_row_search.sv -----
// pipelined binary search for the row that holds a cell index
`default_nettype none
module gcn_row_search #(
   parameter int MAX_FREQUENCY = gcn_pkg::DEFAULT_MAX_FREQUENCY
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             in_valid,
   input  wire logic [gcn_pkg::CELL_W-1:0]                       in_cell,
   input  wire logic [$clog2(MAX_FREQUENCY+1)-1:0]               in_n,
   output logic                                                  out_valid,
   output logic [gcn_pkg::CELL_W-1:0]                            out_cell,
   output logic [$clog2(MAX_FREQUENCY+1)-1:0]                    out_n,
   output logic [((($clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2) > 16) ?
                   $clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2) : 16) + 1)-1:0] out_tot1,
   output logic [$clog2(3*MAX_FREQUENCY+1)-1:0]                  out_row,
   output logic [((($clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2) > 16) ?
                   $clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2) : 16) + 1)-1:0] out_start
);
   import gcn_pkg::*;

   localparam int N_W   = $clog2(MAX_FREQUENCY+1);
   localparam int ROW_W = $clog2(3*MAX_FREQUENCY+1);
   localparam int TOT_W = $clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2);
   localparam int IW    = ((TOT_W > 16) ? TOT_W : 16) + 1;
   localparam int SQ_W  = 2*N_W;

   logic              v_ff    [0:ROW_W];
   logic [CELL_W-1:0] cell_ff [0:ROW_W];
   logic [N_W-1:0]    n_ff    [0:ROW_W];
   logic [IW-1:0]     tot1_ff [0:ROW_W];
   logic [IW-1:0]     sn_ff   [0:ROW_W];
   logic [ROW_W-1:0]  row_ff  [0:ROW_W];
   logic [IW-1:0]     rs_ff   [0:ROW_W];

   logic [SQ_W-1:0]   sq;
   logic [IW-1:0]     sq_ext;
   logic [IW-1:0]     n_ext_iw;
   logic [IW-1:0]     tot1_in;
   logic [IW-1:0]     sn_in;

   // grid constants per transaction: 10n^2+1 and the start of row n
   always_comb begin
      sq       = SQ_W'(in_n) * SQ_W'(in_n);
      sq_ext   = IW'(sq);
      n_ext_iw = IW'(in_n);
      tot1_in  = (sq_ext << 3) + (sq_ext << 1) + IW'(1);
      sn_in    = IW'(1) + (((sq_ext << 2) + sq_ext - (n_ext_iw << 2) - n_ext_iw) >> 1);
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      cell_ff[0] <= in_cell;
      n_ff[0]    <= in_n;
      tot1_ff[0] <= tot1_in;
      sn_ff[0]   <= sn_in;
      row_ff[0]  <= '0;
      rs_ff[0]   <= '0;
   end

   // one row bit decided per stage, most significant first
   for (genvar s = 0; s < ROW_W; s++) begin : g_stage
      localparam int BIT = ROW_W - 1 - s;
      logic [ROW_W-1:0]     cand;
      logic [ROW_W-1:0]     n_ext;
      logic [ROW_W-1:0]     n3;
      logic [ROW_W-1:0]     x;
      logic [2*ROW_W-1:0]   p;
      logic [IW-1:0]        h;
      logic [IW-1:0]        n5;
      logic [IW-1:0]        mid_start;
      logic [IW-1:0]        st;
      logic                 take;

      // start of the candidate row, piecewise over cap, band and cap
      always_comb begin
         cand      = row_ff[s] | (ROW_W'(1) << BIT);
         n_ext     = ROW_W'(n_ff[s]);
         n3        = n_ext + (n_ext << 1);
         x         = (cand <= n_ext) ? cand : (n3 - cand + ROW_W'(1));
         p         = (2*ROW_W)'(x) * (2*ROW_W)'(x - ROW_W'(1));
         h         = IW'((((2*ROW_W+3)'(p) << 2) + (2*ROW_W+3)'(p)) >> 1);
         n5        = (IW'(n_ff[s]) << 2) + IW'(n_ff[s]);
         mid_start = sn_ff[s] + IW'(n5 * IW'(cand - n_ext));
         if (cand <= n_ext) begin
            st = IW'(1) + h;
         end else if (cand <= (n_ext << 1)) begin
            st = mid_start;
         end else begin
            st = tot1_ff[s] - h;
         end
         take = (cand <= n3) && (st <= IW'(cell_ff[s]));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
         cell_ff[s+1] <= cell_ff[s];
         n_ff[s+1]    <= n_ff[s];
         tot1_ff[s+1] <= tot1_ff[s];
         sn_ff[s+1]   <= sn_ff[s];
         row_ff[s+1]  <= take ? cand : row_ff[s];
         rs_ff[s+1]   <= take ? st : rs_ff[s];
      end
   end

   assign out_valid = v_ff[ROW_W];
   assign out_cell  = cell_ff[ROW_W];
   assign out_n     = n_ff[ROW_W];
   assign out_tot1  = tot1_ff[ROW_W];
   assign out_row   = row_ff[ROW_W];
   assign out_start = rs_ff[ROW_W];

endmodule
`default_nettype wire

// ----- sv/geodesic_cell_neighbors.sv -----
// top level: neighbor indices of one cell of an icosahedral geodesic grid
//
// A transaction is accepted at a rising edge with start high and busy low;
// busy is always low, so one cell index can enter every clock cycle.
// The result comes back on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe. The pipeline is the row search, one entry register and one
// row bit per stage, followed by four stages for column, sector, wrapped
// neighbor columns and final indices. Results leave in order. The row
// index is ROW_W = clog2(3*MAX_FREQUENCY+1) bits wide (8 at the default
// of 64). The receiver cannot hold results off, so nothing ever stalls.
// csr_wr_en writes the frequency register (reset value 1); write it only
// while no transaction is in flight. Frequency 0 acts as 1 and values
// above MAX_FREQUENCY act as MAX_FREQUENCY.
// Synchronous reset empties the pipeline and sets the frequency to 1.
// Cell indices at or above 10n^2+2 return rsp_valid_res low, count 0.
`default_nettype none
module geodesic_cell_neighbors #(
   parameter int MAX_FREQUENCY = gcn_pkg::DEFAULT_MAX_FREQUENCY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [gcn_pkg::CELL_W-1:0]    req_cell_req,
   input  wire logic                          csr_wr_en,
   input  wire logic [gcn_pkg::FREQ_W-1:0]    csr_wr_data,
   output logic                               rsp_strobe,
   output logic                               rsp_valid_res,
   output logic [gcn_pkg::COUNT_W-1:0]        rsp_count,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr0,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr1,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr2,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr3,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr4,
   output logic [gcn_pkg::CELL_W-1:0]         rsp_nbr5
);
   import gcn_pkg::*;

   localparam int N_W   = $clog2(MAX_FREQUENCY+1);
   localparam int ROW_W = $clog2(3*MAX_FREQUENCY+1);
   localparam int TOT_W = $clog2(10*MAX_FREQUENCY*MAX_FREQUENCY+2);
   localparam int IW    = ((TOT_W > 16) ? TOT_W : 16) + 1;
   localparam int COL_W = $clog2(5*MAX_FREQUENCY+8) + 1;

   // width of a row in cells
   function automatic logic signed [COL_W-1:0] cells_in_row(
      input logic [ROW_W-1:0] x,
      input logic [ROW_W-1:0] nn
   );
      logic [ROW_W-1:0] n3;
      logic [COL_W-1:0] base;
      n3 = nn + (nn << 1);
      if (x == '0 || x == n3) begin
         base = COL_W'(1);
      end else if (x < nn) begin
         base = COL_W'(x) + (COL_W'(x) << 2);
      end else if (x <= (nn << 1)) begin
         base = COL_W'(nn) + (COL_W'(nn) << 2);
      end else begin
         base = COL_W'(n3 - x) + (COL_W'(n3 - x) << 2);
      end
      return signed'(base);
   endfunction

   // one step of modular wrap into [0, w)
   function automatic logic signed [COL_W-1:0] wrap_col(
      input logic signed [COL_W-1:0] v,
      input logic signed [COL_W-1:0] w
   );
      logic signed [COL_W-1:0] r;
      if (v < 0) begin
         r = v + w;
      end else if (v >= w) begin
         r = v - w;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // frequency register and clamp
   logic [FREQ_W-1:0] freq_ff;
   logic [N_W-1:0]    n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_W'(1);
      end else if (csr_wr_en) begin
         freq_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (freq_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(freq_ff) > 32'(MAX_FREQUENCY)) begin
         n_eff = N_W'(MAX_FREQUENCY);
      end else begin
         n_eff = N_W'(freq_ff);
      end
   end

   assign busy = 1'b0;

   // row search
   logic              s_v;
   logic [CELL_W-1:0] s_cell;
   logic [N_W-1:0]    s_n;
   logic [IW-1:0]     s_tot1;
   logic [ROW_W-1:0]  s_row;
   logic [IW-1:0]     s_start;

   gcn_row_search #(
      .MAX_FREQUENCY(MAX_FREQUENCY)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_cell   (req_cell_req),
      .in_n      (n_eff),
      .out_valid (s_v),
      .out_cell  (s_cell),
      .out_n     (s_n),
      .out_tot1  (s_tot1),
      .out_row   (s_row),
      .out_start (s_start)
   );

   // stage a: column, stride, range check
   logic                    a_v_ff;
   logic                    a_ok_ff,     a_ok_in;
   logic [ROW_W-1:0]        a_row_ff;
   logic [N_W-1:0]          a_n_ff;
   logic [IW-1:0]           a_tot1_ff;
   logic [IW-1:0]           a_rs_ff;
   logic signed [COL_W-1:0] a_col_ff,    a_col_in;
   logic [N_W-1:0]          a_stride_ff, a_stride_in;
   logic [ROW_W-1:0]        s_n_ext;

   always_comb begin
      s_n_ext  = ROW_W'(s_n);
      a_ok_in  = IW'(s_cell) <= s_tot1;
      a_col_in = signed'(COL_W'(IW'(s_cell) - s_start));
      if (s_row < s_n_ext) begin
         a_stride_in = N_W'(s_row);
      end else if (s_row <= (s_n_ext << 1)) begin
         a_stride_in = s_n;
      end else begin
         a_stride_in = N_W'(s_n_ext + (s_n_ext << 1) - s_row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= s_v;
      end
      a_ok_ff     <= a_ok_in;
      a_row_ff    <= s_row;
      a_n_ff      <= s_n;
      a_tot1_ff   <= s_tot1;
      a_rs_ff     <= s_start;
      a_col_ff    <= a_col_in;
      a_stride_ff <= a_stride_in;
   end

   // stage b: sector, pattern code, neighbor row widths and starts
   logic                    b_v_ff;
   logic                    b_ok_ff;
   logic                    b_np_ff,  b_np_in;
   logic                    b_sp_ff,  b_sp_in;
   logic                    b_top_ff, b_top_in;
   logic                    b_bot_ff, b_bot_in;
   logic                    b_mid_ff, b_mid_in;
   logic [3:0]              b_half_ff, b_half_in;
   logic [2:0]              b_sec_ff, b_sec_in;
   logic signed [COL_W-1:0] b_col_ff;
   logic signed [COL_W-1:0] b_wm_ff, b_wm_in;
   logic signed [COL_W-1:0] b_w0_ff, b_w0_in;
   logic signed [COL_W-1:0] b_wp_ff, b_wp_in;
   logic [IW-1:0]           b_rsm_ff, b_rsm_in;
   logic [IW-1:0]           b_rs0_ff;
   logic [IW-1:0]           b_rsp_ff, b_rsp_in;
   logic [IW-1:0]           b_tot1_ff;
   logic [ROW_W-1:0]        a_n_ext;
   logic signed [COL_W-1:0] m1, m2, m3, m4, msel;
   logic                    remz;

   always_comb begin
      a_n_ext  = ROW_W'(a_n_ff);
      b_np_in  = a_row_ff == '0;
      b_sp_in  = a_row_ff == (a_n_ext + (a_n_ext << 1));
      b_top_in = a_row_ff <= a_n_ext;
      b_bot_in = a_row_ff >= (a_n_ext << 1);
      b_mid_in = (a_row_ff >= a_n_ext) && (a_row_ff <= (a_n_ext << 1));
      m1 = signed'(COL_W'(a_stride_ff));
      m2 = m1 <<< 1;
      m3 = m2 + m1;
      m4 = m2 <<< 1;
      if (a_col_ff >= m4) begin
         b_sec_in = 3'd4;
         msel     = m4;
      end else if (a_col_ff >= m3) begin
         b_sec_in = 3'd3;
         msel     = m3;
      end else if (a_col_ff >= m2) begin
         b_sec_in = 3'd2;
         msel     = m2;
      end else if (a_col_ff >= m1) begin
         b_sec_in = 3'd1;
         msel     = m1;
      end else begin
         b_sec_in = 3'd0;
         msel     = '0;
      end
      remz      = a_col_ff == msel;
      b_half_in = {b_mid_in, b_bot_in, b_top_in, remz};
      b_wm_in   = cells_in_row(a_row_ff - ROW_W'(1), a_n_ext);
      b_w0_in   = cells_in_row(a_row_ff, a_n_ext);
      b_wp_in   = cells_in_row(a_row_ff + ROW_W'(1), a_n_ext);
      b_rsm_in  = a_rs_ff - IW'($unsigned(b_wm_in));
      b_rsp_in  = a_rs_ff + IW'($unsigned(b_w0_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
      b_ok_ff   <= a_ok_ff;
      b_np_ff   <= b_np_in;
      b_sp_ff   <= b_sp_in;
      b_top_ff  <= b_top_in;
      b_bot_ff  <= b_bot_in;
      b_mid_ff  <= b_mid_in;
      b_half_ff <= b_half_in;
      b_sec_ff  <= b_sec_in;
      b_col_ff  <= a_col_ff;
      b_wm_ff   <= b_wm_in;
      b_w0_ff   <= b_w0_in;
      b_wp_ff   <= b_wp_in;
      b_rsm_ff  <= b_rsm_in;
      b_rs0_ff  <= a_rs_ff;
      b_rsp_ff  <= b_rsp_in;
      b_tot1_ff <= a_tot1_ff;
   end

   // stage c: shifted columns in the rows above and below, wrapped
   logic                    c_v_ff;
   logic                    c_ok_ff;
   logic                    c_np_ff;
   logic                    c_sp_ff;
   logic [3:0]              c_half_ff;
   logic [IW-1:0]           c_rsm_ff;
   logic [IW-1:0]           c_rs0_ff;
   logic [IW-1:0]           c_rsp_ff;
   logic [IW-1:0]           c_tot1_ff;
   logic signed [COL_W-1:0] c_e_ff,  c_e_in;
   logic signed [COL_W-1:0] c_w_ff,  c_w_in;
   logic signed [COL_W-1:0] c_nw_ff, c_nw_in;
   logic signed [COL_W-1:0] c_nn_ff, c_nn_in;
   logic signed [COL_W-1:0] c_ne_ff, c_ne_in;
   logic signed [COL_W-1:0] c_se_ff, c_se_in;
   logic signed [COL_W-1:0] c_s_ff,  c_s_in;
   logic signed [COL_W-1:0] c_sw_ff, c_sw_in;
   logic signed [COL_W-1:0] secv, nef, sef;

   always_comb begin
      secv = signed'(COL_W'(b_sec_ff));
      if (b_top_ff && b_mid_ff) begin
         nef = b_col_ff - secv;
         sef = b_col_ff;
      end else if (b_bot_ff && b_mid_ff) begin
         nef = b_col_ff;
         sef = b_col_ff - secv;
      end else if (b_mid_ff) begin
         nef = b_col_ff;
         sef = b_col_ff;
      end else if (b_top_ff) begin
         nef = b_col_ff - secv;
         sef = b_col_ff + secv;
      end else begin
         nef = b_col_ff + secv;
         sef = b_col_ff - secv;
      end
      c_e_in  = wrap_col(b_col_ff + COL_W'(1), b_w0_ff);
      c_w_in  = wrap_col(b_col_ff - COL_W'(1), b_w0_ff);
      c_nw_in = wrap_col(nef - COL_W'(1), b_wm_ff);
      c_nn_in = wrap_col(nef, b_wm_ff);
      c_ne_in = wrap_col(nef + COL_W'(1), b_wm_ff);
      c_se_in = wrap_col(sef + COL_W'(1), b_wp_ff);
      c_s_in  = wrap_col(sef, b_wp_ff);
      c_sw_in = wrap_col(sef - COL_W'(1), b_wp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= b_v_ff;
      end
      c_ok_ff   <= b_ok_ff;
      c_np_ff   <= b_np_ff;
      c_sp_ff   <= b_sp_ff;
      c_half_ff <= b_half_ff;
      c_rsm_ff  <= b_rsm_ff;
      c_rs0_ff  <= b_rs0_ff;
      c_rsp_ff  <= b_rsp_ff;
      c_tot1_ff <= b_tot1_ff;
      c_e_ff    <= c_e_in;
      c_w_ff    <= c_w_in;
      c_nw_ff   <= c_nw_in;
      c_nn_ff   <= c_nn_in;
      c_ne_ff   <= c_ne_in;
      c_se_ff   <= c_se_in;
      c_s_ff    <= c_s_in;
      c_sw_ff   <= c_sw_in;
   end

   // stage d: absolute indices, clockwise ordering, output register
   logic                 d_v_ff;
   logic                 d_ok_ff;
   logic [COUNT_W-1:0]   d_cnt_ff, d_cnt_in;
   logic [CELL_W-1:0]    d_nbr_ff [0:5];
   logic [CELL_W-1:0]    d_nbr_in [0:5];
   logic [IW-1:0]        ie, iw, inw, inn, ine, ise, is, isw, sbase;

   always_comb begin
      ie    = c_rs0_ff + IW'($unsigned(c_e_ff));
      iw    = c_rs0_ff + IW'($unsigned(c_w_ff));
      inw   = c_rsm_ff + IW'($unsigned(c_nw_ff));
      inn   = c_rsm_ff + IW'($unsigned(c_nn_ff));
      ine   = c_rsm_ff + IW'($unsigned(c_ne_ff));
      ise   = c_rsp_ff + IW'($unsigned(c_se_ff));
      is    = c_rsp_ff + IW'($unsigned(c_s_ff));
      isw   = c_rsp_ff + IW'($unsigned(c_sw_ff));
      sbase = c_tot1_ff - IW'(5);
      d_cnt_in = COUNT_HEX;
      for (int i = 0; i < 6; i++) begin
         d_nbr_in[i] = '0;
      end
      if (!c_ok_ff) begin
         d_cnt_in = COUNT_NONE;
      end else if (c_np_ff) begin
         d_cnt_in    = COUNT_PENT;
         d_nbr_in[0] = CELL_W'(1);
         d_nbr_in[1] = CELL_W'(5);
         d_nbr_in[2] = CELL_W'(4);
         d_nbr_in[3] = CELL_W'(3);
         d_nbr_in[4] = CELL_W'(2);
      end else if (c_sp_ff) begin
         d_cnt_in = COUNT_PENT;
         for (int i = 0; i < 5; i++) begin
            d_nbr_in[i] = CELL_W'(sbase + IW'(i));
         end
      end else begin
         case (c_half_ff)
            HALF_TOP: begin
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(ise);
               d_nbr_in[2] = CELL_W'(is);
               d_nbr_in[3] = CELL_W'(iw);
               d_nbr_in[4] = CELL_W'(inw);
               d_nbr_in[5] = CELL_W'(inn);
            end
            HALF_TOP_CORNER: begin
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(ise);
               d_nbr_in[2] = CELL_W'(is);
               d_nbr_in[3] = CELL_W'(isw);
               d_nbr_in[4] = CELL_W'(iw);
               d_nbr_in[5] = CELL_W'(inn);
            end
            HALF_BOT_CORNER: begin
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(is);
               d_nbr_in[2] = CELL_W'(iw);
               d_nbr_in[3] = CELL_W'(inw);
               d_nbr_in[4] = CELL_W'(inn);
               d_nbr_in[5] = CELL_W'(ine);
            end
            HALF_N_EDGE: begin
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(is);
               d_nbr_in[2] = CELL_W'(isw);
               d_nbr_in[3] = CELL_W'(iw);
               d_nbr_in[4] = CELL_W'(inw);
               d_nbr_in[5] = CELL_W'(inn);
            end
            HALF_N_CORNER: begin
               d_cnt_in    = COUNT_PENT;
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(is);
               d_nbr_in[2] = CELL_W'(isw);
               d_nbr_in[3] = CELL_W'(iw);
               d_nbr_in[4] = CELL_W'(inn);
            end
            HALF_2N_CORNER: begin
               d_cnt_in    = COUNT_PENT;
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(is);
               d_nbr_in[2] = CELL_W'(iw);
               d_nbr_in[3] = CELL_W'(inn);
               d_nbr_in[4] = CELL_W'(ine);
            end
            default: begin
               d_nbr_in[0] = CELL_W'(ie);
               d_nbr_in[1] = CELL_W'(is);
               d_nbr_in[2] = CELL_W'(isw);
               d_nbr_in[3] = CELL_W'(iw);
               d_nbr_in[4] = CELL_W'(inn);
               d_nbr_in[5] = CELL_W'(ine);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else begin
         d_v_ff <= c_v_ff;
      end
      d_ok_ff  <= c_ok_ff;
      d_cnt_ff <= d_cnt_in;
      for (int i = 0; i < 6; i++) begin
         d_nbr_ff[i] <= d_nbr_in[i];
      end
   end

   // result ports
   assign rsp_strobe    = d_v_ff;
   assign rsp_valid_res = d_ok_ff;
   assign rsp_count     = d_cnt_ff;
   assign rsp_nbr0      = d_nbr_ff[0];
   assign rsp_nbr1      = d_nbr_ff[1];
   assign rsp_nbr2      = d_nbr_ff[2];
   assign rsp_nbr3      = d_nbr_ff[3];
   assign rsp_nbr4      = d_nbr_ff[4];
   assign rsp_nbr5      = d_nbr_ff[5];

endmodule
`default_nettype wire

// ----- tb/tb_geodesic_cell_neighbors.sv -----
// testbench for the geodesic cell neighbor block
`default_nettype none
module tb_geodesic_cell_neighbors;
   import gcn_pkg::*;

   localparam int MAX_N = DEFAULT_MAX_FREQUENCY;

   typedef struct {
      logic                 valid_res;
      logic [COUNT_W-1:0]   count;
      logic [CELL_W-1:0]    nbr [6];
   } nbr_set_type;

   // scoreboard: computes neighbor sets and compares against the block
   class neighbor_board;
      int unsigned freq_reg;
      nbr_set_type pending_sets [$];
      int          errors;

      function new();
         freq_reg = 1;
         errors   = 0;
      endfunction

      function longint grid_n();
         longint n;
         n = freq_reg;
         if (n < 1) n = 1;
         if (n > MAX_N) n = MAX_N;
         return n;
      endfunction

      function longint first_in_row(longint n, longint r);
         longint k;
         if (r <= 0) return 0;
         if (r <= n) return 1 + 5 * r * (r - 1) / 2;
         if (r <= 2 * n) return 1 + 5 * n * (n - 1) / 2 + 5 * n * (r - n);
         k = 3 * n - r;
         return 10 * n * n + 1 - 5 * k * (k + 1) / 2;
      endfunction

      function longint cells_in_row(longint n, longint r);
         if (r == 0 || r == 3 * n) return 1;
         if (r < n) return 5 * r;
         if (r <= 2 * n) return 5 * n;
         return 5 * (3 * n - r);
      endfunction

      function longint wrapped_cell(longint n, longint r, longint c);
         longint w, m;
         w = cells_in_row(n, r);
         m = c % w;
         if (m < 0) m += w;
         return first_in_row(n, r) + m;
      endfunction

      // note an accepted transaction and queue its expected neighbor set
      function void note_cell(logic [CELL_W-1:0] cell_in);
         longint n, cell_idx, row, col, stride, sec, rem, nm, sm, nef, sef;
         longint e, se, s, sw, w, nw, nn, ne;
         longint nb [6];
         int cnt, pat;
         bit top, bot, mid;
         nbr_set_type x;
         n = grid_n();
         cell_idx = cell_in;
         foreach (nb[i]) nb[i] = 0;
         cnt = 6;
         row = 0;
         x.valid_res = 1'b0;
         x.count = COUNT_NONE;
         foreach (x.nbr[i]) x.nbr[i] = '0;
         if (cell_idx >= 10 * n * n + 2) begin
            pending_sets.push_back(x);
            return;
         end
         for (longint r = 1; r <= 3 * n; r++)
            if (first_in_row(n, r) <= cell_idx) row = r;
         col = cell_idx - first_in_row(n, row);
         if (row == 0) begin
            nb[0] = wrapped_cell(n, 1, 0);
            nb[1] = wrapped_cell(n, 1, 4);
            nb[2] = wrapped_cell(n, 1, 3);
            nb[3] = wrapped_cell(n, 1, 2);
            nb[4] = wrapped_cell(n, 1, 1);
            cnt = 5;
         end else if (row == 3 * n) begin
            for (int i = 0; i < 5; i++) nb[i] = wrapped_cell(n, 3 * n - 1, i);
            cnt = 5;
         end else begin
            stride = cells_in_row(n, row) / 5;
            sec = col / stride;
            rem = col % stride;
            top = row <= n;
            bot = row >= 2 * n;
            mid = row >= n && row <= 2 * n;
            pat = (rem == 0) | (top << 1) | (bot << 2) | (mid << 3);
            if (top && mid) begin nm = -1; sm = 0; end
            else if (bot && mid) begin nm = 0; sm = -1; end
            else if (mid) begin nm = 0; sm = 0; end
            else if (top) begin nm = -1; sm = 1; end
            else begin nm = 1; sm = -1; end
            nef = col + nm * sec;
            sef = col + sm * sec;
            e  = wrapped_cell(n, row, col + 1);
            se = wrapped_cell(n, row + 1, sef + 1);
            s  = wrapped_cell(n, row + 1, sef);
            sw = wrapped_cell(n, row + 1, sef - 1);
            w  = wrapped_cell(n, row, col - 1);
            nw = wrapped_cell(n, row - 1, nef - 1);
            nn = wrapped_cell(n, row - 1, nef);
            ne = wrapped_cell(n, row - 1, nef + 1);
            case (pat)
               HALF_TOP:        nb = '{e, se, s, w, nw, nn};
               HALF_TOP_CORNER: nb = '{e, se, s, sw, w, nn};
               HALF_BOT_CORNER: nb = '{e, s, w, nw, nn, ne};
               HALF_N_EDGE:     nb = '{e, s, sw, w, nw, nn};
               HALF_N_CORNER: begin
                  nb = '{e, s, sw, w, nn, 0};
                  cnt = 5;
               end
               HALF_2N_CORNER: begin
                  nb = '{e, s, w, nn, ne, 0};
                  cnt = 5;
               end
               default: nb = '{e, s, sw, w, nn, ne};
            endcase
         end
         x.valid_res = 1'b1;
         x.count = (cnt == 5) ? COUNT_PENT : COUNT_HEX;
         for (int i = 0; i < 6; i++) x.nbr[i] = (i < cnt) ? nb[i][CELL_W-1:0] : '0;
         pending_sets.push_back(x);
      endfunction

      // compare one result with the oldest expected neighbor set
      function void check_result(nbr_set_type got);
         nbr_set_type x;
         if (pending_sets.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         x = pending_sets.pop_front();
         if (got.valid_res !== x.valid_res) begin
            $error("valid_res expected %0d actual %0d", x.valid_res, got.valid_res);
            errors++;
         end
         if (got.count !== x.count) begin
            $error("count expected %0d actual %0d", x.count, got.count);
            errors++;
         end
         for (int i = 0; i < 6; i++)
            if (got.nbr[i] !== x.nbr[i]) begin
               $error("nbr%0d expected %0d actual %0d", i, x.nbr[i], got.nbr[i]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CELL_W-1:0] req_cell_req = '0;
   logic csr_wr_en = 1'b0;
   logic [FREQ_W-1:0] csr_wr_data = '0;
   logic rsp_strobe, rsp_valid_res;
   logic [COUNT_W-1:0] rsp_count;
   logic [CELL_W-1:0] rsp_nbr0, rsp_nbr1, rsp_nbr2, rsp_nbr3, rsp_nbr4, rsp_nbr5;

   neighbor_board board = new();
   bit no_gaps = 0;

   geodesic_cell_neighbors DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cell_req(req_cell_req), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_valid_res(rsp_valid_res), .rsp_count(rsp_count),
      .rsp_nbr0(rsp_nbr0), .rsp_nbr1(rsp_nbr1), .rsp_nbr2(rsp_nbr2),
      .rsp_nbr3(rsp_nbr3), .rsp_nbr4(rsp_nbr4), .rsp_nbr5(rsp_nbr5)
   );

   // clock
   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      nbr_set_type got;
      if (!reset && rsp_strobe) begin
         got.valid_res = rsp_valid_res;
         got.count = rsp_count;
         got.nbr = '{rsp_nbr0, rsp_nbr1, rsp_nbr2, rsp_nbr3, rsp_nbr4, rsp_nbr5};
         board.check_result(got);
      end
   end

   // send one transaction, with an optional idle burst first
   task automatic send_cell(input logic [CELL_W-1:0] cell_idx);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      start <= 1'b1;
      req_cell_req <= cell_idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_cell(cell_idx);
      @(negedge clock);
   endtask

   // drain the pipeline, then write the frequency register
   task automatic write_frequency(input logic [FREQ_W-1:0] value);
      start <= 1'b0;
      while (board.pending_sets.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.freq_reg = value;
   endtask

   // random cell index biased into the valid range of the current grid
   function automatic logic [CELL_W-1:0] pick_cell();
      int unsigned total;
      total = 32'(10 * board.grid_n() * board.grid_n() + 2);
      case ($urandom_range(0, 9))
         0: return CELL_W'($urandom_range(0, 65535));
         1: return CELL_W'(total + $urandom_range(0, 3));
         2: return CELL_W'(total - 1 - $urandom_range(0, 2));
         default: return CELL_W'($urandom_range(0, total - 1));
      endcase
   endfunction

   // stimulus
   initial begin
      int unsigned freqs [10] = '{1, 0, 2, 3, 64, 127, 100, 5, 17, 4};
      int unsigned total;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: poles, row edges, invalid and extreme indices at frequencies 1, 0 and 2
      foreach (freqs[f]) begin
         if (f != 0) write_frequency(FREQ_W'(freqs[f]));
         total = 32'(10 * board.grid_n() * board.grid_n() + 2);
         if (f < 3) begin
            send_cell(CELL_W'(0));
            send_cell(CELL_W'(1));
            send_cell(CELL_W'(5));
            send_cell(CELL_W'(6));
            send_cell(CELL_W'(total - 2));
            send_cell(CELL_W'(total - 1));
            send_cell(CELL_W'(total));
            send_cell(16'hFFFF);
            send_cell(16'h5555);
            send_cell(16'hAAAA);
         end
         for (int i = 0; i < 65; i++) begin
            if (f == 9 && i > 40) no_gaps = 1;
            send_cell(pick_cell());
         end
      end
      start <= 1'b0;
      while (board.pending_sets.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (board.errors == 0)
         $display("[geodesic_cell_neighbors] OK");
      else
         $display("[geodesic_cell_neighbors] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[geodesic_cell_neighbors] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
